### rtl/core/pcm_gain_mix_saturate_unit_assert.svh
// Assertion macros shared by the mixer RTL.
`ifndef PCM_GAIN_MIX_SATURATE_UNIT_ASSERT_SVH
`define PCM_GAIN_MIX_SATURATE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PGMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PGMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/pgms_pkg.sv
package pgms_pkg;

   localparam int OUT_BITS   = 16;
   localparam int SAMPLE_W   = 32;
   localparam int AMP_W      = 17;
   localparam int SHIFT_W    = 6;
   localparam int BYTES_W    = 3;
   localparam int CSR_DATA_W = 32;
   // Amplitude (unsigned) times a signed sample always fits in this width.
   localparam int PROD_W     = AMP_W + SAMPLE_W;

   typedef enum logic [2:0] {
      CSR_MIX_ENABLE    = 3'd0,
      CSR_GAIN_ENABLE   = 3'd1,
      CSR_STEREO_SOURCE = 3'd2,
      CSR_SOURCE_BYTES  = 3'd3,
      CSR_SHIFT_AMOUNT  = 3'd4,
      CSR_AMPLITUDE     = 3'd5
   } pgms_csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] source_left;
      logic signed [SAMPLE_W-1:0] source_right;
      logic signed [OUT_BITS-1:0] dest_left;
      logic signed [OUT_BITS-1:0] dest_right;
      logic                       frame_last;
   } pgms_req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] out_left;
      logic signed [OUT_BITS-1:0] out_right;
      logic                       frame_last_out;
   } pgms_rsp_type;

endpackage

### rtl/core/pcm_gain_mix_saturate_unit.sv
// Stereo PCM gain, mix and saturate unit.
// The req_ channel carries one stereo frame per word: two sign-extended source
// samples, the current output frame and a last-frame flag. The rsp_ channel
// returns the new output frame, one word for every request word, in order.
// The csr_ channel writes the six control registers; write them only while no
// frame is in flight. Writes to undefined indexes are dropped.
// There are three register stages: stage one multiplies by the amplitude,
// stage two applies the signed shift, stage three truncates or does the
// saturating add into the output register. An accepted word moves from the
// stage one register to stage two and on to rsp_data. While rsp_ready is high,
// one frame per cycle is sustained: every stage takes a new word each cycle,
// and stage one holds a single 18x32 multiply per channel.
// When the receiver stalls, the response word holds and the pipeline fills;
// req_ready drops only when all three stages hold a word. Nothing is lost or
// repeated across a stall.
// Synchronous reset empties the pipeline and loads the register defaults:
// overwrite mode, unity gain path, stereo source, two-byte samples, zero shift,
// amplitude of one in fixed point.
`include "pcm_gain_mix_saturate_unit_assert.svh"

module pcm_gain_mix_saturate_unit
   import pgms_pkg::*;
#(
   parameter int AMP_FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  pgms_csr_index_type    csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pgms_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pgms_rsp_type          rsp_data
);

   // Amplitude of one, truncated to the register width like the register itself.
   localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(64'd1 << AMP_FRACTION_BITS);
   localparam int SUM_W = SAMPLE_W + 1;

   // Control registers.
   logic                      mix_enable_ff;
   logic                      gain_enable_ff;
   logic                      stereo_source_ff;
   logic [BYTES_W-1:0]        source_bytes_ff;
   logic signed [SHIFT_W-1:0] shift_amount_ff;
   logic [AMP_W-1:0]          amplitude_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_enable_ff    <= 1'b0;
         gain_enable_ff   <= 1'b0;
         stereo_source_ff <= 1'b1;
         source_bytes_ff  <= BYTES_W'(2);
         shift_amount_ff  <= '0;
         amplitude_ff     <= AMP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIX_ENABLE:    mix_enable_ff    <= csr_data[0];
            CSR_GAIN_ENABLE:   gain_enable_ff   <= csr_data[0];
            CSR_STEREO_SOURCE: stereo_source_ff <= csr_data[0];
            CSR_SOURCE_BYTES:  source_bytes_ff  <= csr_data[BYTES_W-1:0];
            CSR_SHIFT_AMOUNT:  shift_amount_ff  <= signed'(csr_data[SHIFT_W-1:0]);
            CSR_AMPLITUDE:     amplitude_ff     <= csr_data[AMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline flow control: a stage advances when it is empty or its
   // successor advances.
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic adv1;
   logic adv2;
   logic adv3;

   assign adv3      = !rsp_valid_ff || rsp_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Stage one: mono duplication and the amplitude multiply. The value passed
   // on is what the shifter works on. A left shift, or a narrow source, only
   // ever sees the product wrapped to 32 bits; a wide source shifted right
   // keeps the full product.
   logic signed [SAMPLE_W-1:0] sample_in [2];
   logic signed [PROD_W-1:0]   product   [2];
   logic signed [PROD_W-1:0]   s1_value_in [2];
   logic signed [PROD_W-1:0]   s1_value_ff [2];
   logic signed [OUT_BITS-1:0] s1_dest_ff  [2];
   logic                       s1_last_ff;
   logic                       wrap_product;

   assign sample_in[0] = req_data.source_left;
   assign sample_in[1] = stereo_source_ff ? req_data.source_right : req_data.source_left;
   assign wrap_product = (source_bytes_ff <= BYTES_W'(2)) || !shift_amount_ff[SHIFT_W-1];

   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         product[ch] = PROD_W'($signed({1'b0, amplitude_ff})) * PROD_W'(sample_in[ch]);
         if (!gain_enable_ff) begin
            s1_value_in[ch] = PROD_W'(sample_in[ch]);
         end else if (wrap_product) begin
            s1_value_in[ch] = PROD_W'($signed(product[ch][SAMPLE_W-1:0]));
         end else begin
            s1_value_in[ch] = product[ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_value_ff <= s1_value_in;
         s1_dest_ff[0] <= req_data.dest_left;
         s1_dest_ff[1] <= req_data.dest_right;
         s1_last_ff  <= req_data.frame_last;
      end
   end

   // Stage two: the signed shift. A negative amount is an arithmetic right
   // shift by its magnitude, up to 32; the result is wrapped to 32 bits.
   logic [SHIFT_W-1:0]         shift_right;
   logic [SHIFT_W-2:0]         shift_left;
   logic [SAMPLE_W-1:0]        s2_scaled_in [2];
   logic signed [SAMPLE_W-1:0] s2_scaled_ff [2];
   logic signed [OUT_BITS-1:0] s2_dest_ff   [2];
   logic                       s2_last_ff;

   assign shift_right = SHIFT_W'(-shift_amount_ff);
   assign shift_left  = shift_amount_ff[SHIFT_W-2:0];

   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         if (shift_amount_ff[SHIFT_W-1]) begin
            s2_scaled_in[ch] = SAMPLE_W'(s1_value_ff[ch] >>> shift_right);
         end else begin
            s2_scaled_in[ch] = s1_value_ff[ch][SAMPLE_W-1:0] << shift_left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         for (int ch = 0; ch < 2; ch++) begin
            s2_scaled_ff[ch] <= signed'(s2_scaled_in[ch]);
         end
         s2_dest_ff <= s1_dest_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Stage three: write mode truncates the scaled value; mix mode adds it to
   // the existing sample exactly and clamps to the signed output range.
   logic signed [SUM_W-1:0]    sum    [2];
   logic [OUT_BITS-1:0]        result [2];
   logic [SUM_W-OUT_BITS:0]    sum_top;
   pgms_rsp_type               rsp_data_in;
   pgms_rsp_type               rsp_data_ff;

   always_comb begin
      sum_top = '0;
      for (int ch = 0; ch < 2; ch++) begin
         sum[ch] = SUM_W'(s2_dest_ff[ch]) + SUM_W'(s2_scaled_ff[ch]);
         sum_top = sum[ch][SUM_W-1:OUT_BITS-1];
         if (!mix_enable_ff) begin
            result[ch] = s2_scaled_ff[ch][OUT_BITS-1:0];
         end else if ((&sum_top) || !(|sum_top)) begin
            result[ch] = sum[ch][OUT_BITS-1:0];
         end else if (sum[ch][SUM_W-1]) begin
            result[ch] = {1'b1, {(OUT_BITS-1){1'b0}}};
         end else begin
            result[ch] = {1'b0, {(OUT_BITS-1){1'b1}}};
         end
      end
      rsp_data_in.out_left       = signed'(result[0]);
      rsp_data_in.out_right      = signed'(result[1]);
      rsp_data_in.frame_last_out = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

   // An accepted word always lands in stage one.
   `PGMS_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_valid && req_ready, s1_valid_ff,
      "accepted word did not reach stage one")
   // Back-pressure reaches the request side only when every stage is full.
   `PGMS_ASSERT_NOW(a_stall_means_full, clock, reset, !req_ready,
      s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready,
      "request stalled with a free pipeline slot")
   // A word leaving stage two becomes the response.
   `PGMS_ASSERT_NEXT(a_s2_to_rsp, clock, reset, s2_valid_ff && adv3, rsp_valid,
      "stage two word was dropped")

endmodule

### tb/testbench.sv
module testbench
   import pgms_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The amplitude register holds a fixed-point gain with this many fraction bits.
   localparam int AMP_FRACTION = 16;
   // Receiver hold-off used to fill the pipeline and push back on the sender.
   localparam int LONG_STALL_CYCLES = 300;
   localparam int RANDOM_PHASES = 24;

   // Clock and reset. Reset starts high and the stimulus process releases it.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Every input of the block starts out at a known value.
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   pgms_csr_index_type    csr_index = CSR_MIX_ENABLE;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   pgms_req_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   pgms_rsp_type          rsp_data;

   pcm_gain_mix_saturate_unit #(
      .AMP_FRACTION_BITS(AMP_FRACTION)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Our own copy of the control registers, starting from the reset defaults.
   // It changes only when a csr word is accepted, and csr words are only sent
   // while no frame is in flight, so the predictor always sees the settings
   // that the block applies to the same frame.
   bit        cfg_mix = 1'b0;
   bit        cfg_gain = 1'b0;
   bit        cfg_stereo = 1'b1;
   bit [2:0]  cfg_bytes = 3'd2;
   int        cfg_shift = 0;
   bit [16:0] cfg_amp = 17'(1 << AMP_FRACTION);

   // Frames waiting to be offered, and output frames predicted for accepted
   // request words, oldest first.
   pgms_req_type pending[$];
   pgms_rsp_type frames_due[$];

   int frames_queued = 0;
   int frames_accepted = 0;
   int words_checked = 0;
   int error_count = 0;
   int settings_applied = 0;

   // Idle rates in percent, a sender pause flag and a request counter for long
   // receiver stalls. The stimulus process sets these; the driver and the
   // monitor only read them.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit send_hold = 1'b0;
   int stall_asked = 0;

   // Reduces a value to a signed 32-bit quantity, as the datapath does after
   // every shift and, on some paths, after the multiply.
   function automatic longint wrap32(longint v);
      int t;
      t = v[31:0];
      return t;
   endfunction

   // Scaling of one source sample. The unity path only shifts; the gain path
   // multiplies by the amplitude first. With two bytes or fewer the product is
   // kept to 32 bits before a right shift, with wider samples the whole product
   // is shifted. A left shift always works on the 32-bit product.
   function automatic longint scaled_sample(longint s);
      longint p;
      if (!cfg_gain) begin
         if (cfg_shift >= 0) return wrap32(s << cfg_shift);
         return s >>> (-cfg_shift);
      end
      p = longint'(cfg_amp) * s;
      if (cfg_shift >= 0) return wrap32(wrap32(p) << cfg_shift);
      if (cfg_bytes <= 3'd2) p = wrap32(p);
      return wrap32(p >>> (-cfg_shift));
   endfunction

   // Write mode keeps the low output bits of the scaled value. Mix mode adds
   // it to the existing sample exactly and clamps to the signed output range.
   function automatic logic [OUT_BITS-1:0] mixed_sample(longint dest, longint val);
      longint hi;
      longint lo;
      longint sum;
      hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
      lo = -hi - 1;
      if (!cfg_mix) return val[OUT_BITS-1:0];
      sum = dest + val;
      if (sum > hi) sum = hi;
      if (sum < lo) sum = lo;
      return sum[OUT_BITS-1:0];
   endfunction

   // Output frame for one request word. A mono source feeds its left sample
   // to both channels; the right source sample is then ignored.
   function automatic pgms_rsp_type mixed_frame(pgms_req_type f);
      pgms_rsp_type r;
      longint src_l;
      longint src_r;
      src_l = longint'($signed(f.source_left));
      src_r = cfg_stereo ? longint'($signed(f.source_right)) : src_l;
      r.out_left  = mixed_sample(longint'($signed(f.dest_left)), scaled_sample(src_l));
      r.out_right = mixed_sample(longint'($signed(f.dest_right)), scaled_sample(src_r));
      r.frame_last_out = f.frame_last;
      return r;
   endfunction

   // Register update on an accepted csr word. Each register takes only its
   // low bits; writes to undefined indexes leave everything as it was.
   function automatic void store_setting(pgms_csr_index_type idx, logic [31:0] data);
      case (idx)
         CSR_MIX_ENABLE:    cfg_mix = data[0];
         CSR_GAIN_ENABLE:   cfg_gain = data[0];
         CSR_STEREO_SOURCE: cfg_stereo = data[0];
         CSR_SOURCE_BYTES:  cfg_bytes = data[2:0];
         CSR_SHIFT_AMOUNT:  cfg_shift = int'($signed(data[5:0]));
         CSR_AMPLITUDE:     cfg_amp = data[16:0];
         default: ;
      endcase
   endfunction

   // Request driver. A word that is on offer stays on offer, unchanged, until
   // it is accepted; only then may the next one be loaded or valid dropped.
   always @(posedge clock) begin : frame_driver
      logic holding;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding = req_valid;
         if (req_valid && req_ready) begin
            frames_due.push_back(mixed_frame(req_data));
            frames_accepted++;
            holding = 1'b0;
         end
         if (!holding) begin
            if (pending.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. It checks each accepted word against the oldest
   // prediction and drives rsp_ready, either at random or held low for a long
   // stall whenever the stimulus asks for one.
   int stall_given = 0;
   int stall_left = 0;

   always @(posedge clock) begin : frame_monitor
      pgms_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (frames_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected response word: left %0d right %0d last %0b",
                           $signed(rsp_data.out_left), $signed(rsp_data.out_right),
                           rsp_data.frame_last_out);
            end else begin
               want = frames_due.pop_front();
               if (rsp_data.out_left !== want.out_left ||
                   rsp_data.out_right !== want.out_right ||
                   rsp_data.frame_last_out !== want.frame_last_out) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch on word %0d: expected %0d %0d %0b, got %0d %0d %0b",
                              words_checked, $signed(want.out_left), $signed(want.out_right),
                              want.frame_last_out, $signed(rsp_data.out_left),
                              $signed(rsp_data.out_right), rsp_data.frame_last_out);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stall_given != stall_asked) begin
            stall_given = stall_asked;
            stall_left = LONG_STALL_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Waits until every queued frame has been accepted and answered, so that
   // the pipeline is empty and the registers may be written.
   task automatic wait_idle();
      do @(posedge clock);
      while (frames_accepted != frames_queued || frames_due.size() != 0);
   endtask

   // Sends one csr word and waits for it to be taken. Bits above the register
   // width carry random junk half of the time. csr_valid is left high so that
   // back-to-back writes never drop it within a step; the caller lowers it.
   task automatic write_csr(pgms_csr_index_type idx, int width, logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] data;
      mask = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
      data = value & mask;
      if ($urandom_range(1) == 1) data = data | ($urandom & ~mask);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      store_setting(idx, data);
   endtask

   // Writes all six registers in index order. Must be called while idle.
   task automatic set_all(bit mix, bit gain, bit stereo, int bytes, int shift, int amp);
      write_csr(CSR_MIX_ENABLE, 1, 32'(mix));
      write_csr(CSR_GAIN_ENABLE, 1, 32'(gain));
      write_csr(CSR_STEREO_SOURCE, 1, 32'(stereo));
      write_csr(CSR_SOURCE_BYTES, BYTES_W, 32'(bytes));
      write_csr(CSR_SHIFT_AMOUNT, SHIFT_W, 32'(shift));
      write_csr(CSR_AMPLITUDE, AMP_W, 32'(amp));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic push_frame(logic [31:0] src_l, logic [31:0] src_r,
                             logic [15:0] dst_l, logic [15:0] dst_r, bit last);
      pgms_req_type f;
      f.source_left = src_l;
      f.source_right = src_r;
      f.dest_left = dst_l;
      f.dest_right = dst_r;
      f.frame_last = last;
      pending.push_back(f);
      frames_queued++;
   endtask

   // Mostly samples sign-extended from the configured sample size, as a real
   // source delivers them; the rest are full-width noise and the extremes.
   function automatic logic [31:0] random_sample(bit [2:0] bytes);
      logic signed [31:0] t;
      int unsigned pick;
      int pad;
      pick = $urandom_range(99);
      if (pick < 15) return $urandom;
      if (pick < 30) begin
         case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_7fff;
            default: return 32'hffff_8000;
         endcase
      end
      pad = (bytes <= 3'd2) ? 16 : ((bytes >= 3'd4) ? 0 : 8);
      t = $urandom;
      t = t << pad;
      t = t >>> pad;
      // Smaller magnitudes now and then, so that mixing does not always clamp.
      if (pick < 50) t = t >>> $urandom_range(20);
      return t;
   endfunction

   function automatic logic [15:0] random_dest();
      case ($urandom_range(9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_random_frames(int n);
      for (int i = 0; i < n; i++)
         push_frame(random_sample(cfg_bytes), random_sample(cfg_bytes),
                    random_dest(), random_dest(), $urandom_range(7) == 0);
   endtask

   // A random setting, weighted toward shifts that keep some of the sample.
   task automatic random_setting();
      int shift;
      int amp;
      int bytes;
      if ($urandom_range(1) == 1) shift = int'($urandom_range(40)) - 32;
      else shift = int'($urandom_range(63)) - 32;
      case ($urandom_range(9))
         0: amp = 0;
         1: amp = 65536;
         2: amp = 131071;
         3: amp = 1;
         4, 5: amp = $urandom_range(131071);
         default: amp = $urandom_range(81920, 49152);
      endcase
      bytes = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4, 2);
      set_all(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(3) != 0,
              bytes, shift, amp);
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // First stretch of idling: the sender idles less than the receiver.
      send_idle_pct = 29;
      recv_idle_pct = 63;

      // Reset defaults: overwrite mode, unity path, no shift, so the samples
      // are simply truncated to the output width.
      push_frame(32'h7fff_ffff, 32'h8000_0000, 16'h0000, 16'h0000, 1'b0);
      push_frame(32'hffff_ffff, 32'h0000_0000, 16'h7fff, 16'h8000, 1'b1);
      push_frame(32'h0001_2345, 32'hffff_8000, 16'h1234, 16'hedcb, 1'b0);
      wait_idle();

      // Saturating add at both ends of the output range.
      set_all(1, 0, 1, 2, 0, 65536);
      push_frame(32'h0000_7fff, 32'hffff_8000, 16'h7fff, 16'h8000, 1'b0);
      push_frame(32'h7fff_ffff, 32'h8000_0000, 16'h8000, 16'h7fff, 1'b1);
      push_frame(32'h0000_0064, 32'hffff_ff9c, 16'hffce, 16'h0032, 1'b0);
      wait_idle();

      // Unity right shift by the full thirty-two bits in mix mode.
      set_all(1, 0, 1, 4, -32, 65536);
      push_frame(32'h7fff_ffff, 32'h8000_0000, 16'h0005, 16'hfffb, 1'b0);
      push_frame(32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h7fff, 1'b1);
      wait_idle();

      // Unity left shift by the largest amount, where the shifted sample wraps.
      set_all(0, 0, 1, 2, 31, 65536);
      push_frame(32'h0000_0001, 32'h0000_0003, 16'h0000, 16'h0000, 1'b0);
      push_frame(32'hffff_ffff, 32'h7fff_ffff, 16'h1111, 16'h2222, 1'b0);
      wait_idle();

      // Gain path with two-byte samples: the product wraps before the shift,
      // and the largest amplitude is used as given.
      set_all(0, 1, 1, 2, -4, 131071);
      push_frame(32'h0000_7fff, 32'hffff_8000, 16'h0000, 16'h0000, 1'b0);
      push_frame(32'h7fff_ffff, 32'h8000_0000, 16'h0000, 16'h0000, 1'b1);
      wait_idle();

      // Gain path with four-byte samples keeps the whole product.
      set_all(1, 1, 1, 4, -16, 65536);
      push_frame(32'h7fff_ffff, 32'h8000_0000, 16'h1000, 16'hf000, 1'b0);
      push_frame(32'h0012_3456, 32'hffed_cba9, 16'h8000, 16'h7fff, 1'b0);
      wait_idle();

      // Gain with a left shift and a mono source: the right sample is ignored.
      set_all(0, 1, 0, 3, 3, 32768);
      push_frame(32'h0012_3456, 32'hdead_beef, 16'h0000, 16'h0000, 1'b1);
      push_frame(32'hff80_0000, 32'h0000_0000, 16'h5555, 16'haaaa, 1'b0);
      wait_idle();

      // Sample sizes outside two to four bytes, zero amplitude, and the
      // deepest right shift on the gain path.
      set_all(1, 1, 0, 0, -32, 65536);
      push_frame(32'h7fff_ffff, 32'h8000_0000, 16'h0001, 16'hffff, 1'b0);
      wait_idle();
      set_all(1, 1, 1, 7, -32, 0);
      push_frame(32'h8000_0000, 32'h7fff_ffff, 16'h7fff, 16'h8000, 1'b1);
      push_frame(32'h0000_0001, 32'hffff_ffff, 16'h0000, 16'h0000, 1'b0);
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Three stretches of idling: sender light and receiver heavy, then
         // the other way round, then no idling on either side.
         if (phase < RANDOM_PHASES / 3) begin
            send_idle_pct = 29;
            recv_idle_pct = 63;
         end else if (phase < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 63;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // A write to an undefined index must leave every register alone.
         if (phase == 5) write_csr(pgms_csr_index_type'(3'd6), 32, $urandom);
         case (phase)
            0: set_all(1, 1, 1, 7, 31, 131071);
            1: set_all(0, 1, 1, 0, -32, 0);
            2: set_all(1, 0, 0, 4, -32, 65536);
            3: set_all(0, 0, 1, 3, 31, 1);
            default: random_setting();
         endcase
         push_random_frames($urandom_range(68, 40));
         if (phase == 3) begin
            // The receiver stops for a long stretch while the sender keeps
            // offering words, so the pipeline fills and req_ready drops.
            push_random_frames(40);
            stall_asked++;
         end
         if (phase == 12) begin
            // The sender stops partway through and waits until every frame
            // it has sent has come back before it goes on.
            repeat (15) @(posedge clock);
            send_hold = 1'b1;
            do @(posedge clock);
            while (req_valid || frames_due.size() != 0);
            repeat ($urandom_range(40, 10)) @(posedge clock);
            send_hold = 1'b0;
         end
         wait_idle();
      end

      // A final wait after the last frame catches any stray response word.
      repeat (10) @(posedge clock);
      if (frames_due.size() != 0) begin
         error_count++;
         $display("%0d predicted frames never arrived", frames_due.size());
      end
      $display("Checked %0d output frames under %0d register settings, %0d errors.",
               words_checked, settings_applied, error_count);
      $display("Covered write and mix modes, unity and gain paths, mono and stereo sources.");
      if (error_count == 0) begin
         $display("pcm_gain_mix_saturate_unit test passed");
      end else begin
         $display("pcm_gain_mix_saturate_unit test failed");
      end
      $finish;
   end

   // Watchdog: a correct run ends long before this.
   initial begin : watchdog
      #2ms;
      $display("timeout with %0d frames still predicted", frames_due.size());
      $display("pcm_gain_mix_saturate_unit test failed");
      $finish;
   end

endmodule

### pcm_gain_mix_saturate_unit.f
+incdir+rtl/core
rtl/core/pgms_pkg.sv
rtl/core/pcm_gain_mix_saturate_unit.sv
tb/testbench.sv
